### design/cltc_pkg.sv
`default_nettype none

package cltc_pkg;

	// Field widths
	localparam int OFFSET_WIDTH    = 32;
	localparam int LENGTH_WIDTH    = 16;
	localparam int LINE_WIDTH      = 20;
	localparam int KEYWORD_MAX_LEN = 6;
	localparam int PREFIX_IDX_W    = $clog2(KEYWORD_MAX_LEN);

	// Result queue sizing
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Token class codes
	localparam logic [2:0] CLS_KEYWORD = 3'd0;
	localparam logic [2:0] CLS_IDENT   = 3'd1;
	localparam logic [2:0] CLS_NUMBER  = 3'd2;
	localparam logic [2:0] CLS_OPER    = 3'd3;
	localparam logic [2:0] CLS_PUNCT   = 3'd4;

	// Input kind codes
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// Character codes
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_US    = 8'h5F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Keyword table: int, float, if, else, while, return, printf
	localparam int KW_COUNT   = 7;
	localparam int KW_MAX_TXT = 6;
	localparam logic [8*KW_MAX_TXT-1:0] KW_TEXT [KW_COUNT] = '{
		"int", "float", "if", "else", "while", "return", "printf"
	};
	localparam int KW_LEN [KW_COUNT] = '{3, 5, 2, 4, 5, 6, 6};

	typedef struct packed {
		logic [2:0]              token_class;
		logic [2:0]              keyword_index;
		logic [OFFSET_WIDTH-1:0] start_offset;
		logic [LENGTH_WIDTH-1:0] token_length;
		logic [LINE_WIDTH-1:0]   line_number;
		logic [7:0]              first_byte;
		logic                    last_of_run;
	} res_t;

	// Up to two results produced by one transaction, in order
	typedef struct packed {
		logic [1:0] count;
		res_t       r0;
		res_t       r1;
	} res_pair_t;

	typedef struct packed {
		logic [QCNT_W-1:0] level;
		logic              room;
	} qstat_t;

	// Byte j of keyword k, first character at j = 0
	function automatic logic [7:0] kw_byte(input int k, input int j);
		logic [8*KW_MAX_TXT-1:0] s;
		s = KW_TEXT[k];
		return s[8*(KW_LEN[k]-1-j) +: 8];
	endfunction

	function automatic logic is_alpha(input logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return b == CH_SPACE || (b >= 8'h09 && b <= 8'h0D);
	endfunction

	function automatic logic is_oper(input logic [7:0] b);
		return b == CH_EQ || b == CH_PLUS || b == CH_MINUS || b == CH_STAR ||
			b == CH_SLASH || b == CH_LT || b == CH_GT || b == CH_BANG;
	endfunction

endpackage

`default_nettype wire

### design/cltc_scan.sv
`default_nettype none

module cltc_scan import cltc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,
	input  wire logic       kind,
	input  wire logic [7:0] text_byte,
	output res_pair_t       res
);

	typedef enum logic [7:0] {
		M_IDLE  = 8'b0000_0001,
		M_WORD  = 8'b0000_0010,
		M_NUM   = 8'b0000_0100,
		M_OP    = 8'b0000_1000,
		M_SLASH = 8'b0001_0000,
		M_LCMT  = 8'b0010_0000,
		M_BCMT  = 8'b0100_0000,
		M_BSTAR = 8'b1000_0000
	} mode_t;

	mode_t                   mode_q, mode_d;
	logic [LINE_WIDTH-1:0]   line_q, line_d;
	logic [OFFSET_WIDTH-1:0] pos_q, pos_d;
	logic [OFFSET_WIDTH-1:0] start_q, start_d;
	logic [LENGTH_WIDTH-1:0] len_q, len_d;
	logic [LINE_WIDTH-1:0]   tline_q, tline_d;
	logic [7:0]              first_q, first_d;
	logic                    ovf_q, ovf_d;
	logic [7:0]              prefix_q [KEYWORD_MAX_LEN];

	logic                    pre_we;
	logic [PREFIX_IDX_W-1:0] pre_idx;
	logic                    pend;
	logic [LENGTH_WIDTH-1:0] pend_len;
	logic                    punct;
	logic                    fresh;
	logic                    line_inc;
	logic                    word_byte;
	logic [LINE_WIDTH-1:0]   line_next;
	logic [LENGTH_WIDTH-1:0] len_next;
	logic                    kw_hit;
	logic [2:0]              kw_idx;
	res_t                    pend_res, punct_res;

	// Saturating increments
	assign line_next = (line_q == {LINE_WIDTH{1'b1}}) ? line_q : line_q + LINE_WIDTH'(1);
	assign len_next  = (len_q == {LENGTH_WIDTH{1'b1}}) ? len_q : len_q + LENGTH_WIDTH'(1);
	assign word_byte = is_alpha(text_byte) || is_digit(text_byte) || text_byte == CH_US;

	// Match the held word prefix against the keyword table
	always_comb begin
		logic same;
		kw_hit = 1'b0;
		kw_idx = 3'd0;
		for (int k = KW_COUNT - 1; k >= 0; k--) begin
			same = (len_q == LENGTH_WIDTH'(KW_LEN[k])) && !ovf_q;
			for (int j = 0; j < KW_MAX_TXT; j++) begin
				if (j < KW_LEN[k] && prefix_q[j] != kw_byte(k, j)) begin
					same = 1'b0;
				end
			end
			if (same) begin
				kw_hit = 1'b1;
				kw_idx = 3'(k);
			end
		end
	end

	// Next state and results for one transaction
	always_comb begin
		mode_d   = mode_q;
		line_d   = line_q;
		pos_d    = pos_q;
		start_d  = start_q;
		len_d    = len_q;
		tline_d  = tline_q;
		first_d  = first_q;
		ovf_d    = ovf_q;
		pre_we   = 1'b0;
		pre_idx  = len_q[PREFIX_IDX_W-1:0];
		pend     = 1'b0;
		pend_len = len_q;
		punct    = 1'b0;
		fresh    = 1'b0;
		line_inc = 1'b0;

		if (kind == KIND_END) begin
			if (mode_q == M_WORD || mode_q == M_NUM || mode_q == M_OP || mode_q == M_SLASH) begin
				pend = 1'b1;
			end
			mode_d = M_IDLE;
		end else begin
			unique case (mode_q)
				M_LCMT: begin
					if (text_byte == CH_NL) begin
						line_inc = 1'b1;
						mode_d   = M_IDLE;
					end
				end
				M_BCMT: begin
					if (text_byte == CH_STAR) begin
						mode_d = M_BSTAR;
					end else if (text_byte == CH_NL) begin
						line_inc = 1'b1;
					end
				end
				M_BSTAR: begin
					if (text_byte == CH_SLASH) begin
						mode_d = M_IDLE;
					end else if (text_byte != CH_STAR) begin
						line_inc = (text_byte == CH_NL);
						mode_d   = M_BCMT;
					end
				end
				M_WORD: begin
					if (word_byte) begin
						if (ovf_q || {1'b0, len_q} >= (LENGTH_WIDTH+1)'(KEYWORD_MAX_LEN)) begin
							ovf_d = 1'b1;
						end else begin
							pre_we = 1'b1;
						end
						len_d = len_next;
					end else begin
						pend  = 1'b1;
						fresh = 1'b1;
					end
				end
				M_NUM: begin
					if (is_digit(text_byte) || text_byte == CH_DOT) begin
						len_d = len_next;
					end else begin
						pend  = 1'b1;
						fresh = 1'b1;
					end
				end
				M_OP: begin
					pend = 1'b1;
					if (text_byte == CH_EQ) begin
						pend_len = LENGTH_WIDTH'(2);
					end else begin
						pend_len = LENGTH_WIDTH'(1);
						fresh    = 1'b1;
					end
				end
				M_SLASH: begin
					if (text_byte == CH_SLASH) begin
						mode_d = M_LCMT;
					end else if (text_byte == CH_STAR) begin
						mode_d = M_BCMT;
					end else begin
						pend = 1'b1;
						if (text_byte == CH_EQ) begin
							pend_len = LENGTH_WIDTH'(2);
						end else begin
							pend_len = LENGTH_WIDTH'(1);
							fresh    = 1'b1;
						end
					end
				end
				M_IDLE: begin
					fresh = 1'b1;
				end
				default: begin
					fresh = 1'b1;
				end
			endcase

			// A closed token returns the scanner to idle before the byte restarts it
			if (pend) begin
				mode_d = M_IDLE;
			end

			// Start a new token or emit punctuation
			if (fresh) begin
				if (is_space(text_byte)) begin
					line_inc = (text_byte == CH_NL);
				end else if (is_alpha(text_byte) || text_byte == CH_US || is_digit(text_byte) ||
						is_oper(text_byte)) begin
					if (is_alpha(text_byte) || text_byte == CH_US) begin
						mode_d = M_WORD;
					end else if (is_digit(text_byte)) begin
						mode_d = M_NUM;
					end else if (text_byte == CH_SLASH) begin
						mode_d = M_SLASH;
					end else begin
						mode_d = M_OP;
					end
					start_d = pos_q;
					len_d   = LENGTH_WIDTH'(1);
					tline_d = line_q;
					first_d = text_byte;
					ovf_d   = 1'b0;
					pre_we  = 1'b1;
					pre_idx = '0;
				end else begin
					punct = 1'b1;
				end
			end

			if (line_inc) begin
				line_d = line_next;
			end
			pos_d = pos_q + OFFSET_WIDTH'(1);
		end
	end

	// Build the two candidate results
	always_comb begin
		pend_res.token_class   = CLS_OPER;
		pend_res.keyword_index = 3'd0;
		if (mode_q == M_WORD) begin
			pend_res.token_class   = kw_hit ? CLS_KEYWORD : CLS_IDENT;
			pend_res.keyword_index = kw_hit ? kw_idx : 3'd0;
		end else if (mode_q == M_NUM) begin
			pend_res.token_class = CLS_NUMBER;
		end
		pend_res.start_offset = start_q;
		pend_res.token_length = pend_len;
		pend_res.line_number  = tline_q;
		pend_res.first_byte   = first_q;
		pend_res.last_of_run  = !punct;

		punct_res.token_class   = CLS_PUNCT;
		punct_res.keyword_index = 3'd0;
		punct_res.start_offset  = pos_q;
		punct_res.token_length  = LENGTH_WIDTH'(1);
		punct_res.line_number   = line_q;
		punct_res.first_byte    = text_byte;
		punct_res.last_of_run   = 1'b1;
	end

	// Pack results in emission order
	always_comb begin
		res.r0    = pend ? pend_res : punct_res;
		res.r1    = punct_res;
		res.count = take ? (2'(pend) + 2'(punct)) : 2'd0;
	end

	// Advance scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			line_q  <= LINE_WIDTH'(1);
			pos_q   <= '0;
			start_q <= '0;
			len_q   <= '0;
			tline_q <= LINE_WIDTH'(1);
			first_q <= '0;
			ovf_q   <= 1'b0;
		end else if (take) begin
			mode_q  <= mode_d;
			line_q  <= line_d;
			pos_q   <= pos_d;
			start_q <= start_d;
			len_q   <= len_d;
			tline_q <= tline_d;
			first_q <= first_d;
			ovf_q   <= ovf_d;
		end
	end

	// Hold the first bytes of the current word
	always_ff @(posedge clk) begin
		if (take && pre_we) begin
			prefix_q[pre_idx] <= text_byte;
		end
	end

endmodule

`default_nettype wire

### design/cltc_queue.sv
`default_nettype none

module cltc_queue import cltc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire res_pair_t push,
	input  wire logic      pop,
	output res_t           head,
	output qstat_t         stat
);

	res_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] level_q;

	assign head       = mem_q[rd_q];
	assign stat.level = level_q;
	assign stat.room  = level_q <= QCNT_W'(QUEUE_DEPTH - 2);

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			wr_q    <= wr_q + QPTR_W'(push.count);
			rd_q    <= rd_q + QPTR_W'(pop);
			level_q <= level_q + QCNT_W'(push.count) - QCNT_W'(pop);
		end
	end

	// Write up to two results per cycle
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_q + QPTR_W'(1)] <= push.r1;
		end
	end

endmodule

`default_nettype wire

### design/c_like_lexer_token_classifier.sv
// Token classifier for a small C-like language.
// Text channel (text_valid / text_stall / kind / text_byte): one source byte
// per transaction, or an end-of-text marker (kind = 1) that flushes a
// pending word, number or operator and abandons any open comment.
// Token channel (token_valid / token_stall / descriptor fields): one
// descriptor per token; last_of_run marks the final descriptor caused by
// one text transaction.
// Throughput: one text transaction per cycle while text_stall is low.
// A byte that closes a token and is itself punctuation yields two
// descriptors; these drain one per cycle, while token_stall is low,
// through a four-entry result queue. Each descriptor is written into
// the queue when its token completes and is presented from its head.
// text_stall rises while the queue has fewer than two free entries, so
// backpressure on the token channel propagates to the text channel; a
// stalled descriptor holds its value.
// Reset clears the scanner to idle, line count to one, byte offset to zero
// and empties the queue.
`default_nettype none

module c_like_lexer_token_classifier import cltc_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    text_valid,
	output logic                         text_stall,
	input  wire logic                    kind,
	input  wire logic [7:0]              text_byte,
	output logic                         token_valid,
	input  wire logic                    token_stall,
	output logic [2:0]                   token_class,
	output logic [2:0]                   keyword_index,
	output logic [OFFSET_WIDTH-1:0]      start_offset,
	output logic [LENGTH_WIDTH-1:0]      token_length,
	output logic [LINE_WIDTH-1:0]        line_number,
	output logic [7:0]                   first_byte,
	output logic                         last_of_run
);

	logic      take;
	logic      pop;
	res_pair_t results;
	res_t      head;
	qstat_t    qstat;

	assign text_stall  = !qstat.room;
	assign take        = text_valid && !text_stall;
	assign token_valid = qstat.level != '0;
	assign pop         = token_valid && !token_stall;

	cltc_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.kind      (kind),
		.text_byte (text_byte),
		.res       (results)
	);

	cltc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (results),
		.pop    (pop),
		.head   (head),
		.stat   (qstat)
	);

	// Drive descriptor fields from the queue head
	assign token_class   = head.token_class;
	assign keyword_index = head.keyword_index;
	assign start_offset  = head.start_offset;
	assign token_length  = head.token_length;
	assign line_number   = head.line_number;
	assign first_byte    = head.first_byte;
	assign last_of_run   = head.last_of_run;

	// Queue never overfills
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.level <= QCNT_W'(QUEUE_DEPTH))
		else $error("result queue overfilled");

	// An end marker never advances into a second descriptor
	a_end_single: assert property (@(posedge clk) disable iff (!arst_n)
		take && kind == KIND_END |-> results.count != 2'd2)
		else $error("end marker produced two descriptors");

	// Descriptors carry a nonzero length and a nonzero line
	a_len_line: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid |-> token_length != '0 && line_number != '0)
		else $error("descriptor with zero length or line");

	// Only keywords carry a keyword index
	a_kw_index: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_class != CLS_KEYWORD |-> keyword_index == 3'd0)
		else $error("keyword index on non-keyword");

endmodule

`default_nettype wire
